@@ sv/ogru_pkg.sv @@
package ogru_pkg;

  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int COORD_W   = 24;
  localparam int DW        = COORD_W + 2;
  localparam int OPND_W    = 35;
  localparam int PROD_W    = 60;
  localparam int CONV_W    = 62;
  localparam int FRAC_BITS = 39;
  localparam int CRD_W     = 20;
  localparam int ANG_W     = 18;

  localparam logic [7:0]  FREE_STEP = 8'd10;
  localparam logic [7:0]  HIT_STEP  = 8'd50;
  localparam logic [7:0]  CELL_MAX  = 8'd255;
  localparam logic [14:0] OCC_RECIP = 15'd16449;
  localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 20'sd19899;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANG_FIRST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANG_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POSE_X    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POSE_Y    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CELL  = 3'd7;

  localparam logic MODE_BEAM = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [15:0] range_mm;
    logic [11:0] beam_index;
    logic [8:0]  cell_x;
    logic [8:0]  cell_y;
  } in_t;

  typedef struct packed {
    logic [7:0]        cell_value;
    logic signed [7:0] occupancy;
    logic              beam_rejected;
    logic              hit_inside;
  } res_t;

  function automatic logic signed [ANG_W-1:0] atan_lut(input logic [3:0] i);
    case (i)
      4'd0:    atan_lut = 18'sd8192;
      4'd1:    atan_lut = 18'sd4836;
      4'd2:    atan_lut = 18'sd2555;
      4'd3:    atan_lut = 18'sd1297;
      4'd4:    atan_lut = 18'sd651;
      4'd5:    atan_lut = 18'sd326;
      4'd6:    atan_lut = 18'sd163;
      4'd7:    atan_lut = 18'sd81;
      4'd8:    atan_lut = 18'sd41;
      4'd9:    atan_lut = 18'sd20;
      4'd10:   atan_lut = 18'sd10;
      4'd11:   atan_lut = 18'sd5;
      4'd12:   atan_lut = 18'sd3;
      4'd13:   atan_lut = 18'sd1;
      4'd14:   atan_lut = 18'sd1;
      default: atan_lut = 18'sd0;
    endcase
  endfunction

endpackage

@@ sv/ogru_cordic.sv @@
module ogru_cordic import ogru_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [15:0]        ang_i,
  output logic               done_o,
  output logic signed [15:0] cos_o,
  output logic signed [15:0] sin_o
);

  logic                    busy_q, done_q, flip_q;
  logic [3:0]              it_q;
  logic signed [CRD_W-1:0] x_q, y_q;
  logic signed [ANG_W-1:0] z_q, z0;
  logic signed [CRD_W-1:0] shx, shy;
  logic signed [CRD_W:0]   fx, fy;

  always_comb begin
    z0 = ANG_W'($signed(ang_i));
    shx = x_q >>> it_q;
    shy = y_q >>> it_q;
    fx = flip_q ? -(CRD_W+1)'(x_q) : (CRD_W+1)'(x_q);
    fy = flip_q ? -(CRD_W+1)'(y_q) : (CRD_W+1)'(y_q);
    if (fx > 21'sd32767) begin
      cos_o = 16'sd32767;
    end else if (fx < -21'sd32767) begin
      cos_o = -16'sd32767;
    end else begin
      cos_o = fx[15:0];
    end
    if (fy > 21'sd32767) begin
      sin_o = 16'sd32767;
    end else if (fy < -21'sd32767) begin
      sin_o = -16'sd32767;
    end else begin
      sin_o = fy[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        it_q   <= '0;
        x_q    <= CORDIC_GAIN;
        y_q    <= '0;
        // Fold the angle into the right half plane; the sign flip undoes it.
        if (z0 > 18'sd16384) begin
          z_q    <= z0 - 18'sd32768;
          flip_q <= 1'b1;
        end else if (z0 < -18'sd16384) begin
          z_q    <= z0 + 18'sd32768;
          flip_q <= 1'b1;
        end else begin
          z_q    <= z0;
          flip_q <= 1'b0;
        end
      end else if (busy_q) begin
        if (z_q >= 0) begin
          x_q <= x_q - shy;
          y_q <= y_q + shx;
          z_q <= z_q - atan_lut(it_q);
        end else begin
          x_q <= x_q + shy;
          y_q <= y_q - shx;
          z_q <= z_q + atan_lut(it_q);
        end
        it_q <= it_q + 4'd1;
        if (it_q == 4'd15) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;

endmodule

@@ sv/ogru_grid_mem.sv @@
module ogru_grid_mem #(
  parameter int DEPTH = 262144,
  parameter int AW    = 18
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/occupancy_grid_ray_update.sv @@
// Occupancy grid ray update. After reset the block clears its grid memory one
// cell per cycle, with busy_o high; register writes are taken during that
// time. A transaction starts when start_i is high and busy_o is low. Its result
// appears for exactly one cycle with done_o high and must be captured then,
// since the receiver cannot stall the block. A cell read registers the cell
// value and then the result; a rejected beam gives its result in the cycle after
// start. An accepted beam first runs a setup in the iterative sine/cosine unit
// and the coordinate conversion, then walks the line, reading and writing one
// grid cell per cycle through the single memory port pair.
module occupancy_grid_ray_update import ogru_pkg::*; #(
  parameter int GRID_WIDTH  = 512,
  parameter int GRID_HEIGHT = 512
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  in_t                  in_i,
  output logic                 done_o,
  output res_t                 res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(GRID_WIDTH);
  localparam int YW    = $clog2(GRID_HEIGHT);
  localparam logic signed [COORD_W-1:0] W_LIM = COORD_W'(GRID_WIDTH);
  localparam logic signed [COORD_W-1:0] H_LIM = COORD_W'(GRID_HEIGHT);
  localparam logic signed [CONV_W-1:0] W_OFF = CONV_W'(GRID_WIDTH / 2) << FRAC_BITS;
  localparam logic signed [CONV_W-1:0] H_OFF = CONV_W'(GRID_HEIGHT / 2) << FRAC_BITS;
  localparam logic signed [CONV_W-1:0] RND   = (CONV_W'(1) << FRAC_BITS) - CONV_W'(1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD_WAIT, S_RD_OUT, S_ROT, S_PREP, S_MUL, S_CONV,
    S_SETUP, S_WALK, S_FIN
  } state_e;

  function automatic logic inside_grid(input logic signed [COORD_W-1:0] x,
                                       input logic signed [COORD_W-1:0] y);
    inside_grid = (x >= 0) && (x < W_LIM) && (y >= 0) && (y < H_LIM);
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic signed [COORD_W-1:0] x,
                                              input logic signed [COORD_W-1:0] y);
    cell_addr = AW'(y[YW-1:0]) * AW'(GRID_WIDTH) + AW'(x[XW-1:0]);
  endfunction

  state_e state_q;

  logic [15:0] rmin_q, rmax_q, afirst_q, astep_q, heading_q;
  logic signed [15:0] posex_q, posey_q;
  logic [23:0] inv_q;

  logic [15:0] range_q;
  logic [15:0] ang_q;
  logic        rot_start_q;
  logic        rot_done;
  logic signed [15:0] cos_w, sin_w;
  logic signed [15:0] cos_q, sin_q;
  logic signed [OPND_W-1:0] ex_q, ey_q, px_w, py_w, opnd;
  logic signed [PROD_W-1:0] prod_q;
  logic [1:0] k_q;
  logic signed [CONV_W-1:0] conv_v, conv_r, conv_t;
  logic signed [COORD_W-1:0] x0_q, y0_q, x1_q, y1_q, conv_c;
  logic signed [DW-1:0] dx_q, dy_q, err_q;
  logic signed [DW:0]   e2;
  logic hit_q;

  logic          rd_in_q;
  logic [7:0]    v_q;
  logic [14:0]   v100;
  logic [29:0]   occ_p;

  logic          p_vld_q, p_hit_q;
  logic [AW-1:0] p_addr_q;
  logic [AW-1:0] clr_q;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  logic          done_q;
  res_t          res_q;

  logic signed [COORD_W-1:0] rx, ry;
  logic [15:0] idx_mul;

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  assign rx = COORD_W'($signed({1'b0, in_i.cell_x}));
  assign ry = COORD_W'($signed({1'b0, in_i.cell_y}));
  assign idx_mul = 16'(in_i.beam_index * astep_q);

  assign px_w = OPND_W'(posex_q) <<< 15;
  assign py_w = OPND_W'(posey_q) <<< 15;

  always_comb begin
    case (k_q)
      2'd0:    opnd = px_w;
      2'd1:    opnd = py_w;
      2'd2:    opnd = ex_q;
      default: opnd = ey_q;
    endcase
    // Odd steps are rows, whose axis points the other way.
    conv_v = k_q[0] ? (H_OFF - CONV_W'(prod_q)) : (CONV_W'(prod_q) + W_OFF);
    conv_r = conv_v + (conv_v[CONV_W-1] ? RND : '0);
    conv_t = conv_r >>> FRAC_BITS;
    conv_c = conv_t[COORD_W-1:0];
    e2     = (DW+1)'(err_q) <<< 1;
    v100   = (15'(v_q) << 6) + (15'(v_q) << 5) + (15'(v_q) << 2);
    occ_p  = v100 * OCC_RECIP;
  end

  // Memory port selection.
  always_comb begin
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = p_vld_q;
      mem_waddr = p_addr_q;
      if (p_hit_q) begin
        mem_wdata = (mem_rdata > CELL_MAX - HIT_STEP) ? CELL_MAX : mem_rdata + HIT_STEP;
      end else begin
        mem_wdata = (mem_rdata > FREE_STEP) ? mem_rdata - FREE_STEP : '0;
      end
    end
    if (state_q == S_WALK) begin
      mem_raddr = cell_addr(x0_q, y0_q);
    end else begin
      mem_raddr = cell_addr(rx, ry);
    end
  end

  ogru_grid_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ogru_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rot_start_q),
    .ang_i   (ang_q),
    .done_o  (rot_done),
    .cos_o   (cos_w),
    .sin_o   (sin_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rmin_q    <= 16'd0;
      rmax_q    <= 16'd30000;
      afirst_q  <= 16'd0;
      astep_q   <= 16'd182;
      posex_q   <= 16'sd0;
      posey_q   <= 16'sd0;
      heading_q <= 16'd0;
      inv_q     <= 24'd335544;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RANGE_MIN: rmin_q    <= cfg_wdata_i[15:0];
        REG_RANGE_MAX: rmax_q    <= cfg_wdata_i[15:0];
        REG_ANG_FIRST: afirst_q  <= cfg_wdata_i[15:0];
        REG_ANG_STEP:  astep_q   <= cfg_wdata_i[15:0];
        REG_POSE_X:    posex_q   <= $signed(cfg_wdata_i[15:0]);
        REG_POSE_Y:    posey_q   <= $signed(cfg_wdata_i[15:0]);
        REG_HEADING:   heading_q <= cfg_wdata_i[15:0];
        REG_INV_CELL:  inv_q     <= cfg_wdata_i;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      done_q      <= 1'b0;
      p_vld_q     <= 1'b0;
      p_hit_q     <= 1'b0;
      rot_start_q <= 1'b0;
      k_q         <= '0;
    end else begin
      done_q      <= 1'b0;
      p_vld_q     <= 1'b0;
      p_hit_q     <= 1'b0;
      rot_start_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start_i) begin
            range_q <= in_i.range_mm;
            if (in_i.mode == MODE_READ) begin
              rd_in_q <= inside_grid(rx, ry);
              state_q <= S_RD_WAIT;
            end else if (in_i.range_mm < rmin_q || in_i.range_mm > rmax_q) begin
              done_q <= 1'b1;
              res_q  <= '{cell_value: 8'd0, occupancy: 8'sd0,
                         beam_rejected: 1'b1, hit_inside: 1'b0};
            end else begin
              ang_q       <= heading_q + afirst_q + idx_mul;
              rot_start_q <= 1'b1;
              state_q     <= S_ROT;
            end
          end
        end
        S_RD_WAIT: begin
          v_q     <= rd_in_q ? mem_rdata : 8'd0;
          state_q <= S_RD_OUT;
        end
        S_RD_OUT: begin
          done_q  <= 1'b1;
          res_q   <= '{cell_value: v_q,
                       occupancy: (v_q == 8'd0) ? -8'sd1 : $signed(occ_p[29:22]),
                       beam_rejected: 1'b0, hit_inside: 1'b0};
          state_q <= S_IDLE;
        end
        S_ROT: begin
          if (rot_done) begin
            cos_q   <= cos_w;
            sin_q   <= sin_w;
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          ex_q    <= px_w + OPND_W'($signed({1'b0, range_q}) * cos_q);
          ey_q    <= py_w + OPND_W'($signed({1'b0, range_q}) * sin_q);
          k_q     <= 2'd0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          prod_q  <= PROD_W'(opnd * $signed({1'b0, inv_q}));
          state_q <= S_CONV;
        end
        S_CONV: begin
          case (k_q)
            2'd0:    x0_q <= conv_c;
            2'd1:    y0_q <= conv_c;
            2'd2:    x1_q <= conv_c;
            default: y1_q <= conv_c;
          endcase
          k_q     <= k_q + 2'd1;
          state_q <= (k_q == 2'd3) ? S_SETUP : S_MUL;
        end
        S_SETUP: begin
          dx_q    <= (x1_q >= x0_q) ? DW'(x1_q - x0_q) : DW'(x0_q - x1_q);
          dy_q    <= (y1_q >= y0_q) ? DW'(y0_q - y1_q) : DW'(y1_q - y0_q);
          err_q   <= ((x1_q >= x0_q) ? DW'(x1_q - x0_q) : DW'(x0_q - x1_q))
                   + ((y1_q >= y0_q) ? DW'(y0_q - y1_q) : DW'(y1_q - y0_q));
          hit_q   <= inside_grid(x1_q, y1_q);
          state_q <= S_WALK;
        end
        S_WALK: begin
          // Line cells are all distinct, so a read may overlap the previous
          // cell's write-back without forwarding.
          p_addr_q <= mem_raddr;
          p_vld_q  <= inside_grid(x0_q, y0_q);
          if (x0_q != x1_q || y0_q != y1_q) begin
            if (e2 >= (DW+1)'(dy_q)) begin
              x0_q <= (x1_q > x0_q) ? x0_q + 24'sd1 : x0_q - 24'sd1;
            end
            if (e2 <= (DW+1)'(dx_q)) begin
              y0_q <= (y1_q > y0_q) ? y0_q + 24'sd1 : y0_q - 24'sd1;
            end
            err_q <= err_q + ((e2 >= (DW+1)'(dy_q)) ? dy_q : '0)
                           + ((e2 <= (DW+1)'(dx_q)) ? dx_q : '0);
          end else begin
            p_hit_q <= 1'b1;
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          done_q  <= 1'b1;
          res_q   <= '{cell_value: 8'd0, occupancy: 8'sd0,
                       beam_rejected: 1'b0, hit_inside: hit_q};
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ test/occupancy_grid_ray_update_tb.sv @@
`timescale 1ns / 1ps

module occupancy_grid_ray_update_tb;
  import ogru_pkg::*;

  localparam int GW = 512;
  localparam int GH = 512;
  localparam int CYCLE_LIMIT = 10000000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  in_t                  in_i = '0;
  logic                 done_o;
  res_t                 res_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;

  occupancy_grid_ray_update u_top (
    .clk_i, .rst_ni, .start_i, .busy_o, .in_i, .done_o, .res_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always #5 clk_i = ~clk_i;

  // Mirror of the block's registers and grid.
  logic [15:0] lim_min = 16'd0, lim_max = 16'd30000;
  logic [15:0] ang_first = 16'd0, ang_step = 16'd182, heading = 16'd0;
  logic signed [15:0] pose_x = '0, pose_y = '0;
  logic [23:0] inv_cell = 24'd335544;
  logic [7:0]  grid [GW*GH];

  in_t  pending_items[$];
  res_t expected_res[$];
  int   hit_cells[$];
  int   idle_pct = 0;
  int   errors = 0;
  int   cycles = 0;
  logic took = 1'b0;

  const int atan_q15[16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                             41, 20, 10, 5, 3, 1, 1, 0};

  function automatic void cordic_sin_cos(input logic [15:0] ang, output int c, output int s);
    int z, x, y, nx;
    bit flip;
    z = int'($signed(ang));
    x = 19899;
    y = 0;
    flip = 0;
    if (z > 16384) begin
      z -= 32768; flip = 1;
    end else if (z < -16384) begin
      z += 32768; flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= atan_q15[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += atan_q15[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x; y = -y;
    end
    if (x > 32767) x = 32767;
    if (x < -32767) x = -32767;
    if (y > 32767) y = 32767;
    if (y < -32767) y = -32767;
    c = x;
    s = y;
  endfunction

  function automatic longint trunc39(input longint v);
    if (v >= 0) return v >>> 39;
    return -((-v) >>> 39);
  endfunction

  function automatic bit on_grid(input longint x, input longint y);
    return x >= 0 && x < GW && y >= 0 && y < GH;
  endfunction

  // Casts one beam into the grid mirror; returns whether the end cell is on the grid.
  function automatic bit cast_beam(input logic [15:0] range_mm, input logic [11:0] idx);
    int c, s;
    longint inv, px, py, x0, y0, x1, y1, dx, dy, err, e2, cx;
    logic [15:0] ang;
    inv = longint'(inv_cell);
    ang = heading + ang_first + 16'(32'(idx) * 32'(ang_step));
    cordic_sin_cos(ang, c, s);
    px = longint'(pose_x) * 32768;
    py = longint'(pose_y) * 32768;
    x0 = trunc39(px * inv + (longint'(GW / 2) <<< 39));
    y0 = trunc39((longint'(GH / 2) <<< 39) - py * inv);
    x1 = trunc39((px + longint'(range_mm) * c) * inv + (longint'(GW / 2) <<< 39));
    y1 = trunc39((longint'(GH / 2) <<< 39) - (py + longint'(range_mm) * s) * inv);
    dx = x1 >= x0 ? x1 - x0 : x0 - x1;
    dy = y1 >= y0 ? y0 - y1 : y1 - y0;
    err = dx + dy;
    while (x0 != x1 || y0 != y1) begin
      if (on_grid(x0, y0)) begin
        cx = y0 * GW + x0;
        grid[cx] = grid[cx] > FREE_STEP ? grid[cx] - FREE_STEP : 8'd0;
      end
      e2 = 2 * err;
      if (e2 >= dy) begin
        err += dy; x0 += (x1 > x0) ? 1 : -1;
      end
      if (e2 <= dx) begin
        err += dx; y0 += (y1 > y0) ? 1 : -1;
      end
    end
    if (!on_grid(x1, y1)) return 1'b0;
    cx = y1 * GW + x1;
    grid[cx] = grid[cx] > CELL_MAX - HIT_STEP ? CELL_MAX : grid[cx] + HIT_STEP;
    hit_cells.push_back(int'(cx));
    if (hit_cells.size() > 64) void'(hit_cells.pop_front());
    return 1'b1;
  endfunction

  function automatic res_t predict_result(input in_t it);
    res_t r;
    logic [7:0] v;
    r = '0;
    if (it.mode == MODE_READ) begin
      v = grid[int'(it.cell_y) * GW + int'(it.cell_x)];
      r.cell_value = v;
      r.occupancy = (v == 0) ? -8'sd1 : 8'(int'(v) * 100 / 255);
    end else if (it.range_mm < lim_min || it.range_mm > lim_max) begin
      r.beam_rejected = 1'b1;
    end else begin
      r.hit_inside = cast_beam(it.range_mm, it.beam_index);
    end
    return r;
  endfunction

  function automatic in_t beam_item(input logic [15:0] range_mm, input logic [11:0] idx);
    in_t it;
    it = in_t'({$urandom, $urandom});
    it.mode = MODE_BEAM;
    it.range_mm = range_mm;
    it.beam_index = idx;
    return it;
  endfunction

  function automatic in_t read_item(input logic [8:0] x, input logic [8:0] y);
    in_t it;
    it = in_t'({$urandom, $urandom});
    it.mode = MODE_READ;
    it.cell_x = x;
    it.cell_y = y;
    return it;
  endfunction

  function automatic in_t random_item();
    int cx, sel;
    logic [15:0] r;
    sel = $urandom_range(99);
    if (sel < 55) begin
      if (lim_min <= lim_max && $urandom_range(99) < 85)
        r = 16'($urandom_range(int'(lim_max), int'(lim_min)));
      else if ($urandom_range(1)) r = 16'($urandom);
      else r = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      return beam_item(r, 12'($urandom));
    end
    if (hit_cells.size() > 0 && sel < 90) begin
      cx = hit_cells[$urandom_range(hit_cells.size() - 1)];
      return read_item(9'((cx % GW) + $urandom_range(2) - 1),
                       9'((cx / GW) + $urandom_range(2) - 1));
    end
    return read_item(9'($urandom), 9'($urandom));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val16,
                           input logic [23:0] val24 = 24'd0);
    logic [23:0] wd;
    wd = (idx == REG_INV_CELL) ? val24 : {8'($urandom), val16};
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= wd;
    case (idx)
      REG_RANGE_MIN: lim_min = wd[15:0];
      REG_RANGE_MAX: lim_max = wd[15:0];
      REG_ANG_FIRST: ang_first = wd[15:0];
      REG_ANG_STEP:  ang_step = wd[15:0];
      REG_POSE_X:    pose_x = wd[15:0];
      REG_POSE_Y:    pose_y = wd[15:0];
      REG_HEADING:   heading = wd[15:0];
      default:       inv_cell = wd;
    endcase
  endtask

  task automatic set_config(input logic [15:0] rmin, input logic [15:0] rmax,
                            input logic [15:0] afirst, input logic [15:0] astep,
                            input logic [15:0] px, input logic [15:0] py,
                            input logic [15:0] hd, input logic [23:0] inv);
    write_reg(REG_RANGE_MIN, rmin);
    write_reg(REG_RANGE_MAX, rmax);
    write_reg(REG_ANG_FIRST, afirst);
    write_reg(REG_ANG_STEP, astep);
    write_reg(REG_POSE_X, px);
    write_reg(REG_POSE_Y, py);
    write_reg(REG_HEADING, hd);
    write_reg(REG_INV_CELL, 16'd0, inv);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || expected_res.size() != 0 || start_i)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic run_random(input int n, input int idle);
    idle_pct = idle;
    for (int i = 0; i < n; i++) pending_items.push_back(random_item());
    drain();
  endtask

  // Driver: a new transaction is presented once the previous one has been taken.
  always @(negedge clk_i) begin
    if (!start_i || took) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start_i <= 1'b1;
        in_i <= pending_items.pop_front();
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: predicts at acceptance, checks every strobed result.
  always @(posedge clk_i) begin
    res_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else if (rst_ni) begin
      took <= start_i && !busy_o;
      if (start_i && !busy_o) expected_res.push_back(predict_result(in_i));
      if (done_o) begin
        if (expected_res.size() == 0) begin
          $error("unexpected result %p", res_o);
          errors++;
        end else begin
          e = expected_res.pop_front();
          if (res_o.cell_value !== e.cell_value) begin
            $error("cell_value expected %0d actual %0d", e.cell_value, res_o.cell_value);
            errors++;
          end
          if (res_o.occupancy !== e.occupancy) begin
            $error("occupancy expected %0d actual %0d", e.occupancy, res_o.occupancy);
            errors++;
          end
          if (res_o.beam_rejected !== e.beam_rejected) begin
            $error("beam_rejected expected %0b actual %0b", e.beam_rejected,
                   res_o.beam_rejected);
            errors++;
          end
          if (res_o.hit_inside !== e.hit_inside) begin
            $error("hit_inside expected %0b actual %0b", e.hit_inside, res_o.hit_inside);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < GW * GH; i++) grid[i] = 8'd0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // The grid is cleared after reset; wait until the block is ready.
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);

    // Directed items under the reset settings.
    pending_items.push_back(read_item(9'd256, 9'd256));
    pending_items.push_back(beam_item(16'd0, 12'd0));
    pending_items.push_back(read_item(9'd256, 9'd256));
    pending_items.push_back(beam_item(16'd0, 12'd4095));
    pending_items.push_back(beam_item(16'd30000, 12'd0));
    pending_items.push_back(beam_item(16'd30001, 12'd0));
    pending_items.push_back(beam_item(16'hFFFF, 12'd4095));
    pending_items.push_back(beam_item(16'd1000, 12'd500));
    pending_items.push_back(beam_item(16'd29999, 12'd1000));
    for (int i = 0; i < 6; i++) pending_items.push_back(beam_item(16'd0, 12'($urandom)));
    pending_items.push_back(read_item(9'd256, 9'd256));
    pending_items.push_back(read_item(9'd0, 9'd0));
    pending_items.push_back(read_item(9'd511, 9'd511));
    pending_items.push_back(read_item(9'd0, 9'd511));
    drain();

    // Zero inverse cell size: every point lands on the center cell.
    set_config(16'd0, 16'hFFFF, 16'd0, 16'd182, 16'd0, 16'd0, 16'd0, 24'd0);
    pending_items.push_back(beam_item(16'hFFFF, 12'd7));
    pending_items.push_back(read_item(9'd256, 9'd256));
    drain();
    // Crossed limits reject every beam.
    set_config(16'd500, 16'd100, 16'h1234, 16'd1, 16'h7FFF, 16'h8000, 16'hFFFF, 24'd335544);
    pending_items.push_back(beam_item(16'd300, 12'd0));
    pending_items.push_back(beam_item(16'd500, 12'd0));
    drain();

    set_config(16'd0, 16'hFFFF, 16'd0, 16'd182, 16'd0, 16'd0, 16'd0, 24'd335544);
    run_random(150, 0);
    // Robot far off the grid: rays enter and leave it.
    set_config(16'd1000, 16'd20000, 16'h8000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF,
               24'd335544);
    run_random(120, 52);
    set_config(16'd500, 16'd100, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 24'd335544);
    run_random(40, 20);
    // One cell per millimeter keeps the ranges short.
    set_config(16'd0, 16'd300, 16'd0, 16'd91, 16'd100, 16'hFF38, 16'h4000, 24'hFFFFFF);
    run_random(120, 0);
    set_config(16'd0, 16'hFFFF, 16'd0, 16'd16, 16'h8000, 16'h7FFF, 16'd0, 24'd1);
    run_random(80, 52);
    set_config(16'd0, 16'hFFFF, 16'd0, 16'd5, 16'd0, 16'd0, 16'd0, 24'd0);
    run_random(40, 20);
    for (int p = 0; p < 4; p++) begin
      set_config(16'($urandom_range(2000)), 16'($urandom_range(65535, 20000)),
                 16'($urandom), 16'($urandom), 16'($urandom_range(16000) - 8000),
                 16'($urandom_range(16000) - 8000), 16'($urandom),
                 24'($urandom_range(700000, 100000)));
      run_random(115, (p % 2) ? 52 : 20);
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/ogru_pkg.sv
sv/ogru_cordic.sv
sv/ogru_grid_mem.sv
sv/occupancy_grid_ray_update.sv
test/occupancy_grid_ray_update_tb.sv
